/* design/dam_pkg.sv */
// Shared types, constants and helper functions for the decimal accumulator machine.
// No dependencies; every other file in the block but dam_ram imports this package.
package dam_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int MEM_WORDS     = 100;
	localparam int ADDR_W        = 7;
	localparam int OUT_W         = 32;

	// instruction split: word / 100 and word % 100 for words below 4400
	localparam int RADIX       = 100;
	localparam int DEC_LIMIT   = 4400;
	localparam int DEC_W       = 13;
	localparam int RECIP       = 1311;
	localparam int RECIP_W     = 11;
	localparam int RECIP_SHIFT = 17;
	localparam int PROD_W      = DEC_W + RECIP_W;
	localparam int Q_W         = 6;

	localparam logic [Q_W-1:0] OPC_READ  = Q_W'(10);
	localparam logic [Q_W-1:0] OPC_WRITE = Q_W'(11);
	localparam logic [Q_W-1:0] OPC_LOAD  = Q_W'(20);
	localparam logic [Q_W-1:0] OPC_STORE = Q_W'(21);
	localparam logic [Q_W-1:0] OPC_ADD   = Q_W'(30);
	localparam logic [Q_W-1:0] OPC_SUB   = Q_W'(31);
	localparam logic [Q_W-1:0] OPC_MUL   = Q_W'(32);
	localparam logic [Q_W-1:0] OPC_DIV   = Q_W'(33);
	localparam logic [Q_W-1:0] OPC_JUMP  = Q_W'(40);
	localparam logic [Q_W-1:0] OPC_HALT  = Q_W'(43);

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_OPCODE = 2'd1;
	localparam logic [1:0] ERR_DIV0   = 2'd2;

	typedef enum logic [1:0] {
		OPN_WRITE, OPN_START, OPN_START_ENTRY, OPN_EXEC
	} oper_t;

	typedef enum logic [3:0] {
		I_READ, I_WRITE, I_LOAD, I_STORE, I_ADD, I_SUB,
		I_MUL, I_DIV, I_JUMP, I_HALT, I_BAD
	} instr_t;

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_FETCH, S_OPERAND, S_EXEC, S_ALU, S_FINISH
	} state_t;

	typedef enum logic [1:0] {RD_NONE, RD_PC, RD_OPA} rd_sel_t;
	typedef enum logic [1:0] {MW_NONE, MW_ITEM, MW_INPUT, MW_ACC} mw_sel_t;
	typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ALU} acc_sel_t;
	typedef enum logic [2:0] {PC_HOLD, PC_NEXT, PC_JUMP, PC_START, PC_ENTRY} pc_sel_t;
	typedef enum logic [2:0] {ST_NONE, ST_RUN, ST_HALT, ST_BAD, ST_DIV0} stop_sel_t;

	typedef struct packed {
		logic      latch;
		rd_sel_t   rd;
		logic      decode;
		mw_sel_t   mw;
		acc_sel_t  acc;
		pc_sel_t   pc;
		stop_sel_t stop;
		logic      set_out;
		logic      set_in;
		logic      alu_go;
		logic      alu_div;
		logic      res_load;
	} cmd_t;

	typedef struct packed {
		oper_t  op;
		logic   addr_ok;
		logic   stopped;
		instr_t instr;
		logic   opnd_zero;
		logic   alu_done;
	} sts_t;

	function automatic instr_t decode_op(input logic [Q_W-1:0] q);
		instr_t r;
		unique case (q)
			OPC_READ:  r = I_READ;
			OPC_WRITE: r = I_WRITE;
			OPC_LOAD:  r = I_LOAD;
			OPC_STORE: r = I_STORE;
			OPC_ADD:   r = I_ADD;
			OPC_SUB:   r = I_SUB;
			OPC_MUL:   r = I_MUL;
			OPC_DIV:   r = I_DIV;
			OPC_JUMP:  r = I_JUMP;
			OPC_HALT:  r = I_HALT;
			default:   r = I_BAD;
		endcase
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] mod_addr(input logic [ADDR_W-1:0] a);
		return (a >= ADDR_W'(MEM_WORDS)) ? a - ADDR_W'(MEM_WORDS) : a;
	endfunction

endpackage

/* design/dam_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dam_ram #(
	parameter int Width = 32,
	parameter int Depth = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/dam_alu.sv */
// Bit-serial multiply (shift-add) and restoring divide, one bit per cycle.
// Uses dam_pkg; instantiated by dam_datapath.
module dam_alu
	import dam_pkg::*;
#(
	parameter int Width = WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             div,
	input  logic [Width-1:0] a,
	input  logic [Width-1:0] b,
	output logic             done,
	output logic [Width-1:0] result
);

	localparam int CntW = $clog2(Width + 1);

	logic            run_q;
	logic            done_q;
	logic            div_q;
	logic [CntW-1:0] cnt_q;
	logic [Width-1:0] x_q;
	logic [Width-1:0] y_q;
	logic [Width-1:0] p_q;
	logic [Width:0]   rem_sh;
	logic [Width:0]   diff;

	assign rem_sh = {p_q, x_q[Width-1]};
	assign diff   = rem_sh - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(Width);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			div_q <= div;
			x_q   <= a;
			y_q   <= b;
			p_q   <= '0;
		end else if (run_q) begin
			if (div_q) begin
				if (!diff[Width]) begin
					p_q <= diff[Width-1:0];
					x_q <= {x_q[Width-2:0], 1'b1};
				end else begin
					p_q <= rem_sh[Width-1:0];
					x_q <= {x_q[Width-2:0], 1'b0};
				end
			end else begin
				p_q <= p_q + (y_q[0] ? x_q : '0);
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? x_q : p_q;

endmodule

/* design/dam_datapath.sv */
// Datapath: program memory with per-word valid bits, accumulator, pc, flags,
// instruction split, iterative multiply/divide and the result register.
// Uses dam_pkg, dam_ram and dam_alu; driven by dam_ctrl commands.
module dam_datapath
	import dam_pkg::*;
#(
	parameter int WordBits = WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic [1:0]        operation,
	input  logic [ADDR_W-1:0] address,
	input  logic [31:0]       write_value,
	input  logic [31:0]       in_value,
	output logic              out_valid,
	output logic [OUT_W-1:0]  out_value,
	output logic              input_used,
	output logic              halted,
	output logic [1:0]        error_code,
	output logic [ADDR_W-1:0] program_counter_out
);

	// latched request
	logic [1:0]        op_q;
	logic [ADDR_W-1:0] ad_q;
	logic [31:0]       wv_q;
	logic [31:0]       iv_q;

	logic [ADDR_W-1:0]   entry_q;
	logic [WordBits-1:0] acc_q;
	logic [ADDR_W-1:0]   pc_q;
	logic                stop_q;
	logic [1:0]          err_q;
	logic [MEM_WORDS-1:0] vld_q;
	logic                rvld_s1;
	logic [ADDR_W-1:0]   opa_q;
	instr_t              instr_q;
	logic                ov_q;
	logic                iu_q;
	logic [OUT_W-1:0]    oval_q;

	logic                res_ov_q;
	logic [OUT_W-1:0]    res_oval_q;
	logic                res_iu_q;
	logic                res_halt_q;
	logic [1:0]          res_err_q;
	logic [ADDR_W-1:0]   res_pc_q;

	logic                re;
	logic [ADDR_W-1:0]   raddr;
	logic [WordBits-1:0] rdata;
	logic [WordBits-1:0] opnd;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [WordBits-1:0] wdata;

	logic                dec_ok;
	logic [DEC_W-1:0]    lw;
	logic [PROD_W-1:0]   prod;
	logic [Q_W-1:0]      q6;
	logic [DEC_W-1:0]    rem;

	logic                alu_done;
	logic [WordBits-1:0] alu_res;

	assign re    = (cmd.rd != RD_NONE);
	assign raddr = (cmd.rd == RD_OPA) ? opa_q : pc_q;

	always_comb begin
		we    = 1'b1;
		waddr = opa_q;
		wdata = acc_q;
		unique case (cmd.mw)
			MW_ITEM: begin
				waddr = ad_q;
				wdata = WordBits'(wv_q);
			end
			MW_INPUT: wdata = WordBits'(iv_q);
			MW_ACC:   wdata = acc_q;
			MW_NONE:  we = 1'b0;
			default:  we = 1'b0;
		endcase
	end

	dam_ram #(
		.Width (WordBits),
		.Depth (MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// unwritten words read as zero
	assign opnd = rvld_s1 ? rdata : '0;

	// word / 100 by reciprocal; only words below 4400 can hold a known opcode
	assign dec_ok = (opnd < WordBits'(DEC_LIMIT));
	assign lw     = opnd[DEC_W-1:0];
	assign prod   = PROD_W'(lw) * PROD_W'(RECIP);
	assign q6     = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
	assign rem    = lw - DEC_W'(q6) * DEC_W'(RADIX);

	dam_alu #(
		.Width (WordBits)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.alu_go),
		.div    (cmd.alu_div),
		.a      (acc_q),
		.b      (opnd),
		.done   (alu_done),
		.result (alu_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= operation;
			ad_q <= address;
			wv_q <= write_value;
			iv_q <= in_value;
		end
		if (cmd.decode) begin
			instr_q <= dec_ok ? decode_op(q6) : I_BAD;
			opa_q   <= rem[ADDR_W-1:0];
		end
		if (cmd.res_load) begin
			res_ov_q   <= ov_q;
			res_oval_q <= oval_q;
			res_iu_q   <= iu_q;
			res_halt_q <= stop_q;
			res_err_q  <= err_q;
			res_pc_q   <= pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			acc_q   <= '0;
			pc_q    <= '0;
			stop_q  <= 1'b1;
			err_q   <= ERR_NONE;
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
			ov_q    <= 1'b0;
			iu_q    <= 1'b0;
			oval_q  <= '0;
		end else begin
			if (cfg_we) begin
				entry_q <= cfg_data;
			end
			if (re) begin
				rvld_s1 <= vld_q[raddr];
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cmd.latch) begin
				ov_q   <= 1'b0;
				iu_q   <= 1'b0;
				oval_q <= '0;
			end
			if (cmd.set_out) begin
				ov_q   <= 1'b1;
				oval_q <= OUT_W'(opnd);
			end
			if (cmd.set_in) begin
				iu_q <= 1'b1;
			end
			unique case (cmd.acc)
				ACC_LOAD: acc_q <= opnd;
				ACC_ADD:  acc_q <= acc_q + opnd;
				ACC_SUB:  acc_q <= acc_q - opnd;
				ACC_ALU:  acc_q <= alu_res;
				ACC_HOLD: acc_q <= acc_q;
				default:  acc_q <= acc_q;
			endcase
			unique case (cmd.pc)
				PC_NEXT:  pc_q <= (pc_q == ADDR_W'(MEM_WORDS - 1)) ? '0 : pc_q + 1'b1;
				PC_JUMP:  pc_q <= opa_q;
				PC_START: pc_q <= mod_addr(ad_q);
				PC_ENTRY: pc_q <= mod_addr(entry_q);
				PC_HOLD:  pc_q <= pc_q;
				default:  pc_q <= pc_q;
			endcase
			unique case (cmd.stop)
				ST_RUN: begin
					stop_q <= 1'b0;
					err_q  <= ERR_NONE;
				end
				ST_HALT: begin
					stop_q <= 1'b1;
					err_q  <= ERR_NONE;
				end
				ST_BAD: begin
					stop_q <= 1'b1;
					err_q  <= ERR_OPCODE;
				end
				ST_DIV0: begin
					stop_q <= 1'b1;
					err_q  <= ERR_DIV0;
				end
				ST_NONE: stop_q <= stop_q;
				default: stop_q <= stop_q;
			endcase
		end
	end

	assign sts.op        = oper_t'(op_q);
	assign sts.addr_ok   = (ad_q < ADDR_W'(MEM_WORDS));
	assign sts.stopped   = stop_q;
	assign sts.instr     = instr_q;
	assign sts.opnd_zero = (opnd == '0);
	assign sts.alu_done  = alu_done;

	assign out_valid           = res_ov_q;
	assign out_value           = res_oval_q;
	assign input_used          = res_iu_q;
	assign halted              = res_halt_q;
	assign error_code          = res_err_q;
	assign program_counter_out = res_pc_q;

endmodule

/* design/dam_ctrl.sv */
// Controller state machine: request/result handshakes and per-step commands.
// Uses dam_pkg; talks to dam_datapath through cmd_t and sts_t.
module dam_ctrl
	import dam_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic res_valid,
	input  logic res_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				unique case (sts.op)
					OPN_WRITE: begin
						if (sts.addr_ok) begin
							cmd.mw = MW_ITEM;
						end
					end
					OPN_START: begin
						cmd.pc   = PC_START;
						cmd.stop = ST_RUN;
					end
					OPN_START_ENTRY: begin
						cmd.pc   = PC_ENTRY;
						cmd.stop = ST_RUN;
					end
					OPN_EXEC: begin
						if (!sts.stopped) begin
							cmd.rd  = RD_PC;
							state_d = S_FETCH;
						end
					end
				endcase
			end
			S_FETCH: begin
				cmd.decode = 1'b1;
				state_d    = S_OPERAND;
			end
			S_OPERAND: begin
				cmd.rd  = RD_OPA;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FINISH;
				unique case (sts.instr)
					I_READ: begin
						cmd.mw     = MW_INPUT;
						cmd.set_in = 1'b1;
						cmd.pc     = PC_NEXT;
					end
					I_WRITE: begin
						cmd.set_out = 1'b1;
						cmd.pc      = PC_NEXT;
					end
					I_LOAD: begin
						cmd.acc = ACC_LOAD;
						cmd.pc  = PC_NEXT;
					end
					I_STORE: begin
						cmd.mw = MW_ACC;
						cmd.pc = PC_NEXT;
					end
					I_ADD: begin
						cmd.acc = ACC_ADD;
						cmd.pc  = PC_NEXT;
					end
					I_SUB: begin
						cmd.acc = ACC_SUB;
						cmd.pc  = PC_NEXT;
					end
					I_MUL: begin
						cmd.alu_go = 1'b1;
						state_d    = S_ALU;
					end
					I_DIV: begin
						if (sts.opnd_zero) begin
							cmd.stop = ST_DIV0;
						end else begin
							cmd.alu_go  = 1'b1;
							cmd.alu_div = 1'b1;
							state_d     = S_ALU;
						end
					end
					I_JUMP: cmd.pc = PC_JUMP;
					I_HALT: cmd.stop = ST_HALT;
					default: cmd.stop = ST_BAD;
				endcase
			end
			S_ALU: begin
				if (sts.alu_done) begin
					cmd.acc = ACC_ALU;
					cmd.pc  = PC_NEXT;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!res_valid_q || res_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

endmodule

/* design/decimal_accumulator_machine_cu_core.sv */
// Top level of the decimal accumulator machine: controller plus datapath.
// Uses dam_pkg, dam_ctrl and dam_datapath.
//
// One request at a time, one result per request, held in an output register so
// the next request is taken while a result waits. A memory write or a start goes
// through dispatch and finish; an executed instruction adds pc fetch, split,
// operand read and execute through one RAM read port; multiply and divide
// go through a bit-serial unit doing one bit per cycle; the block is ready
// again in the cycle after the result is loaded. Memory reads as zero after
// reset through per-word valid bits, so there is no clearing pass.
// cfg_ready is always high; write entry_address only while idle.
module decimal_accumulator_machine_cu_core
	import dam_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        operation,
	input  logic [ADDR_W-1:0] address,
	input  logic [31:0]       write_value,
	input  logic [31:0]       in_value,
	output logic              res_valid,
	input  logic              res_ready,
	output logic              out_valid,
	output logic [OUT_W-1:0]  out_value,
	output logic              input_used,
	output logic              halted,
	output logic [1:0]        error_code,
	output logic [ADDR_W-1:0] program_counter_out
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	dam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dam_datapath #(
		.WordBits (WORD_BITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_we              (cfg_valid & cfg_ready),
		.cfg_data            (cfg_data),
		.operation           (operation),
		.address             (address),
		.write_value         (write_value),
		.in_value            (in_value),
		.out_valid           (out_valid),
		.out_value           (out_value),
		.input_used          (input_used),
		.halted              (halted),
		.error_code          (error_code),
		.program_counter_out (program_counter_out)
	);

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (error_code == ERR_NONE || halted))
		else $error("error reported on a running machine");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (program_counter_out < ADDR_W'(MEM_WORDS)))
		else $error("pc out of memory range");

	a_one_io: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_valid && input_used))
		else $error("output and input in one result");

	a_quiet_out: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (out_value == '0))
		else $error("out_value nonzero without output");

endmodule
